>>> rtl/first_fit_heap_allocator_defines.svh
// assertion macros for the first fit heap allocator
// used by the top level only, no other dependencies
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffha assertion failed");

// next-cycle implication
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffha assertion failed");

`endif

>>> rtl/ffha_pkg.sv
// shared types and constants of the first fit heap allocator
// used by the controller, the datapath and the top level
package ffha_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOMEM    = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_BADPTR   = 3'd3;
  localparam logic [2:0] ST_DBLFREE  = 3'd4;
  localparam logic [2:0] ST_CORRUPT  = 3'd5;

  localparam logic [1:0] TAG_NONE = 2'd0;
  localparam logic [1:0] TAG_FREE = 2'd1;
  localparam logic [1:0] TAG_USED = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;

  localparam int CFG_W = 17;
  localparam logic [CFG_W-1:0] FLOOR_RESET = 17'd16384;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_ZERO, OP_A_INIT, OP_RD_CUR, OP_A_TAKE,
    OP_A_WCUR, OP_A_LINK, OP_A_ADV, OP_B_INIT, OP_B_ADV, OP_B_FIN,
    OP_F_BADPTR, OP_F_CORRUPT, OP_F_DOUBLE, OP_RD_G, OP_F_TAKE, OP_F_ADV,
    OP_F_PLACE, OP_RD_NX, OP_F_MERGE, OP_F_WBLK, OP_PUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_alloc;
    logic zero_req;
    logic v;
    logic fit;
    logic range_bad;
    logic unaligned;
    logic tag_free;
    logic tag_used;
    logic walk_on;
    logic nx_adj;
  } dp_stat_t;

endpackage

>>> rtl/ffha_dp.sv
// datapath of the first fit heap allocator: header memory, list walk
// registers and statistics; driven by ffha_ctrl, uses ffha_pkg
module ffha_dp #(
  parameter int POOL_BYTES   = 65536,
  parameter int ALIGN_BYTES  = 16,
  parameter int HEADER_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ffha_pkg::dp_cmd_t             cmd_i,
  output ffha_pkg::dp_stat_t            stat_o,
  input  logic                          cfg_wr_en,
  input  logic [ffha_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          command,
  input  logic [15:0]                   request_bytes,
  input  logic [15:0]                   payload_offset,
  output logic [2:0]                    status,
  output logic [15:0]                   granted_offset,
  output logic [16:0]                   live_bytes,
  output logic [16:0]                   peak_bytes,
  output logic [16:0]                   largest_free,
  output logic [16:0]                   largest_request,
  output logic                          high_water_step
);

  localparam int DEPTH = POOL_BYTES / ALIGN_BYTES;
  localparam int IX_W  = $clog2(DEPTH);
  localparam int AL_W  = $clog2(ALIGN_BYTES);
  localparam int SZ_W  = $clog2(POOL_BYTES) + 1;
  localparam int AW    = SZ_W + 2;
  localparam int LV_W  = ((SZ_W > 17) ? SZ_W : 17) + 1;
  localparam int CW    = ((SZ_W > 17) ? SZ_W : 17) + 2;

  typedef struct packed {
    logic [SZ_W-1:0] size;
    logic [IX_W-1:0] next;
    logic            has;
    logic [1:0]      tag;
  } hdr_t;

  hdr_t mem [DEPTH];
  hdr_t rdata, wd, prevd, gd, blkd;
  logic we;
  logic [IX_W-1:0] wa, ra;

  logic [IX_W-1:0] clr_idx, cur, prev, blk, head, link;
  logic v, pv, head_v, link_v;
  logic cmd_r;
  logic [15:0] req_r, off_r;
  logic [16:0] size_r;
  logic [SZ_W-1:0] live, peak, best;
  logic [16:0] maxreq;
  logic [LV_W-1:0] rlevel;
  logic [ffha_pkg::CFG_W-1:0] floor;
  logic [2:0] res_status;
  logic [15:0] res_granted;
  logic [SZ_W-1:0] res_lfree;
  logic res_step;

  logic [16:0] rounded;
  logic [CW-1:0] need_split;
  logic split;
  logic [IX_W-1:0] ng, gidx;
  logic [31:0] b_w;
  logic [SZ_W-1:0] live_add, live_sub;
  logic [LV_W-1:0] lvl;
  logic merge_prev;
  logic [AW-1:0] prev_end, g_base, blk_end, nx_base;

  assign rounded    = (17'(request_bytes == 16'd0 ? req_r : req_r) + 17'(ALIGN_BYTES - 1))
                      & ~17'(ALIGN_BYTES - 1);
  assign need_split = CW'(size_r) + CW'(HEADER_BYTES) + CW'(ALIGN_BYTES);
  assign split      = CW'(rdata.size) > need_split;
  assign ng         = cur + IX_W'(HEADER_BYTES / ALIGN_BYTES) + IX_W'(size_r >> AL_W);
  assign b_w        = 32'(off_r) - 32'(HEADER_BYTES);
  assign gidx       = IX_W'(b_w >> AL_W);
  assign live_add   = live + gd.size + SZ_W'(HEADER_BYTES);
  assign live_sub   = rdata.size + SZ_W'(HEADER_BYTES);
  assign lvl        = (rlevel != '0) ? (rlevel << 1) : LV_W'(floor);
  assign prev_end   = (AW'(prev) << AL_W) + AW'(HEADER_BYTES) + AW'(prevd.size);
  assign g_base     = AW'(gidx) << AL_W;
  assign merge_prev = pv && (prev_end == g_base);
  assign blk_end    = (AW'(blk) << AL_W) + AW'(HEADER_BYTES) + AW'(blkd.size);
  assign nx_base    = AW'(blkd.next) << AL_W;

  always_comb begin
    stat_o.clear_done = (clr_idx == IX_W'(DEPTH - 1));
    stat_o.is_alloc   = (cmd_r == ffha_pkg::CMD_ALLOC);
    stat_o.zero_req   = (req_r == 16'd0);
    stat_o.v          = v;
    stat_o.fit        = CW'(rdata.size) >= CW'(size_r);
    stat_o.range_bad  = (32'(off_r) < 32'(HEADER_BYTES)) || (b_w >= 32'(POOL_BYTES));
    stat_o.unaligned  = (b_w[AL_W-1:0] != '0);
    stat_o.tag_free   = (rdata.tag == ffha_pkg::TAG_FREE);
    stat_o.tag_used   = (rdata.tag == ffha_pkg::TAG_USED);
    stat_o.walk_on    = v && (cur < gidx);
    stat_o.nx_adj     = blkd.has && (blk_end == nx_base);
  end

  // memory write and read address selection
  always_comb begin
    we = 1'b0;
    wa = cur;
    wd = gd;
    ra = cur;
    case (cmd_i.op)
      ffha_pkg::OP_CLEAR: begin
        we = 1'b1;
        wa = clr_idx;
        wd = '0;
        if (clr_idx == '0) begin
          wd.size = SZ_W'(POOL_BYTES - HEADER_BYTES);
          wd.tag  = ffha_pkg::TAG_FREE;
        end
      end
      ffha_pkg::OP_A_TAKE: begin
        we = split;
        wa = ng;
        wd.size = rdata.size - SZ_W'(size_r) - SZ_W'(HEADER_BYTES);
        wd.next = rdata.next;
        wd.has  = rdata.has;
        wd.tag  = ffha_pkg::TAG_FREE;
      end
      ffha_pkg::OP_A_WCUR: begin
        we = 1'b1;
        wa = cur;
        wd = gd;
      end
      ffha_pkg::OP_A_LINK: begin
        we = pv;
        wa = prev;
        wd = prevd;
        wd.next = link;
        wd.has  = link_v;
      end
      ffha_pkg::OP_RD_G: ra = gidx;
      ffha_pkg::OP_F_PLACE: begin
        we = 1'b1;
        if (merge_prev) begin
          wa = gidx;
          wd = gd;
          wd.tag = ffha_pkg::TAG_NONE;
        end else begin
          wa = prev;
          wd = prevd;
          wd.next = gidx;
          wd.has  = 1'b1;
          we = pv;
        end
      end
      ffha_pkg::OP_RD_NX: ra = blkd.next;
      ffha_pkg::OP_F_MERGE: begin
        we = 1'b1;
        wa = blkd.next;
        wd = rdata;
        wd.tag = ffha_pkg::TAG_NONE;
      end
      ffha_pkg::OP_F_WBLK: begin
        we = 1'b1;
        wa = blk;
        wd = blkd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx         <= '0;
      head            <= '0;
      head_v          <= 1'b1;
      live            <= '0;
      peak            <= '0;
      maxreq          <= '0;
      rlevel          <= '0;
      floor           <= ffha_pkg::FLOOR_RESET;
      v               <= 1'b0;
      pv              <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        floor <= cfg_wr_data;
      end
      case (cmd_i.op)
        ffha_pkg::OP_CLEAR: clr_idx <= clr_idx + 1'b1;
        ffha_pkg::OP_LOAD: begin
          cmd_r       <= command;
          req_r       <= request_bytes;
          off_r       <= payload_offset;
          res_granted <= '0;
          res_lfree   <= '0;
          res_step    <= 1'b0;
        end
        ffha_pkg::OP_ZERO: res_status <= ffha_pkg::ST_ZERO;
        ffha_pkg::OP_A_INIT: begin
          size_r <= rounded;
          cur    <= head;
          v      <= head_v;
          pv     <= 1'b0;
        end
        ffha_pkg::OP_A_TAKE: begin
          gd <= rdata;
          gd.tag <= ffha_pkg::TAG_USED;
          if (split) begin
            gd.size <= SZ_W'(size_r);
            gd.next <= ng;
            gd.has  <= 1'b1;
            link    <= ng;
            link_v  <= 1'b1;
          end else begin
            link    <= rdata.next;
            link_v  <= rdata.has;
          end
        end
        ffha_pkg::OP_A_LINK: begin
          if (!pv) begin
            head   <= link;
            head_v <= link_v;
          end
          live <= live_add;
          if (size_r > maxreq) begin
            maxreq <= size_r;
          end
          if (live_add > peak) begin
            peak <= live_add;
            if (LV_W'(live_add) >= lvl) begin
              rlevel   <= lvl;
              res_step <= 1'b1;
            end
          end
          res_status  <= ffha_pkg::ST_OK;
          res_granted <= 16'((32'(cur) << AL_W) + 32'(HEADER_BYTES));
        end
        ffha_pkg::OP_A_ADV, ffha_pkg::OP_F_ADV: begin
          prev  <= cur;
          prevd <= rdata;
          pv    <= 1'b1;
          cur   <= rdata.next;
          v     <= rdata.has;
        end
        ffha_pkg::OP_B_INIT: begin
          best <= '0;
          cur  <= head;
          v    <= head_v;
        end
        ffha_pkg::OP_B_ADV: begin
          if (rdata.size > best) begin
            best <= rdata.size;
          end
          cur <= rdata.next;
          v   <= rdata.has;
        end
        ffha_pkg::OP_B_FIN: begin
          res_status <= ffha_pkg::ST_NOMEM;
          res_lfree  <= best;
        end
        ffha_pkg::OP_F_BADPTR:  res_status <= ffha_pkg::ST_BADPTR;
        ffha_pkg::OP_F_CORRUPT: res_status <= ffha_pkg::ST_CORRUPT;
        ffha_pkg::OP_F_DOUBLE:  res_status <= ffha_pkg::ST_DBLFREE;
        ffha_pkg::OP_F_TAKE: begin
          gd  <= rdata;
          if (live >= live_sub) begin
            live <= live - live_sub;
          end
          cur <= head;
          v   <= head_v;
          pv  <= 1'b0;
        end
        ffha_pkg::OP_F_PLACE: begin
          if (merge_prev) begin
            blk  <= prev;
            blkd <= prevd;
            blkd.size <= prevd.size + SZ_W'(HEADER_BYTES) + gd.size;
          end else begin
            blk       <= gidx;
            blkd.size <= gd.size;
            blkd.next <= cur;
            blkd.has  <= v;
            blkd.tag  <= ffha_pkg::TAG_FREE;
            if (!pv) begin
              head   <= gidx;
              head_v <= 1'b1;
            end
          end
        end
        ffha_pkg::OP_F_MERGE: begin
          blkd.size <= blkd.size + SZ_W'(HEADER_BYTES) + rdata.size;
          blkd.next <= rdata.next;
          blkd.has  <= rdata.has;
        end
        ffha_pkg::OP_F_WBLK: res_status <= ffha_pkg::ST_OK;
        ffha_pkg::OP_PUSH: begin
          status          <= res_status;
          granted_offset  <= res_granted;
          live_bytes      <= 17'(live);
          peak_bytes      <= 17'(peak);
          largest_free    <= 17'(res_lfree);
          largest_request <= maxreq;
          high_water_step <= res_step;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/ffha_ctrl.sv
// controller state machine of the first fit heap allocator
// sequences ffha_dp through commands; uses ffha_pkg
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ffha_pkg::dp_stat_t stat_i,
  output ffha_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_A_TEST, S_A_EVAL, S_A_WCUR, S_A_LINK,
    S_B_TEST, S_B_EVAL, S_F_TAG, S_F_TEST, S_F_EVAL, S_F_NXCHK,
    S_F_NXMRG, S_F_WBLK, S_DONE
  } state_t;

  state_t state, state_next;
  logic out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cmd_o.op       = ffha_pkg::OP_NONE;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_CLEAR: begin
        cmd_o.op = ffha_pkg::OP_CLEAR;
        if (stat_i.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.op   = ffha_pkg::OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.is_alloc) begin
          if (stat_i.zero_req) begin
            cmd_o.op   = ffha_pkg::OP_ZERO;
            state_next = S_DONE;
          end else begin
            cmd_o.op   = ffha_pkg::OP_A_INIT;
            state_next = S_A_TEST;
          end
        end else if (stat_i.range_bad) begin
          cmd_o.op   = ffha_pkg::OP_F_BADPTR;
          state_next = S_DONE;
        end else if (stat_i.unaligned) begin
          cmd_o.op   = ffha_pkg::OP_F_CORRUPT;
          state_next = S_DONE;
        end else begin
          cmd_o.op   = ffha_pkg::OP_RD_G;
          state_next = S_F_TAG;
        end
      end
      S_A_TEST: begin
        if (stat_i.v) begin
          cmd_o.op   = ffha_pkg::OP_RD_CUR;
          state_next = S_A_EVAL;
        end else begin
          cmd_o.op   = ffha_pkg::OP_B_INIT;
          state_next = S_B_TEST;
        end
      end
      S_A_EVAL: begin
        if (stat_i.fit) begin
          cmd_o.op   = ffha_pkg::OP_A_TAKE;
          state_next = S_A_WCUR;
        end else begin
          cmd_o.op   = ffha_pkg::OP_A_ADV;
          state_next = S_A_TEST;
        end
      end
      S_A_WCUR: begin
        cmd_o.op   = ffha_pkg::OP_A_WCUR;
        state_next = S_A_LINK;
      end
      S_A_LINK: begin
        cmd_o.op   = ffha_pkg::OP_A_LINK;
        state_next = S_DONE;
      end
      S_B_TEST: begin
        if (stat_i.v) begin
          cmd_o.op   = ffha_pkg::OP_RD_CUR;
          state_next = S_B_EVAL;
        end else begin
          cmd_o.op   = ffha_pkg::OP_B_FIN;
          state_next = S_DONE;
        end
      end
      S_B_EVAL: begin
        cmd_o.op   = ffha_pkg::OP_B_ADV;
        state_next = S_B_TEST;
      end
      S_F_TAG: begin
        if (stat_i.tag_free) begin
          cmd_o.op   = ffha_pkg::OP_F_DOUBLE;
          state_next = S_DONE;
        end else if (!stat_i.tag_used) begin
          cmd_o.op   = ffha_pkg::OP_F_CORRUPT;
          state_next = S_DONE;
        end else begin
          cmd_o.op   = ffha_pkg::OP_F_TAKE;
          state_next = S_F_TEST;
        end
      end
      S_F_TEST: begin
        if (stat_i.walk_on) begin
          cmd_o.op   = ffha_pkg::OP_RD_CUR;
          state_next = S_F_EVAL;
        end else begin
          cmd_o.op   = ffha_pkg::OP_F_PLACE;
          state_next = S_F_NXCHK;
        end
      end
      S_F_EVAL: begin
        cmd_o.op   = ffha_pkg::OP_F_ADV;
        state_next = S_F_TEST;
      end
      S_F_NXCHK: begin
        if (stat_i.nx_adj) begin
          cmd_o.op   = ffha_pkg::OP_RD_NX;
          state_next = S_F_NXMRG;
        end else begin
          state_next = S_F_WBLK;
        end
      end
      S_F_NXMRG: begin
        cmd_o.op   = ffha_pkg::OP_F_MERGE;
        state_next = S_F_WBLK;
      end
      S_F_WBLK: begin
        cmd_o.op   = ffha_pkg::OP_F_WBLK;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd_o.op       = ffha_pkg::OP_PUSH;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/first_fit_heap_allocator.sv
// first fit heap allocator: an allocate walks the free list block by block and, on failure,
// walks it again for the largest free block; a free walks to its list place the same way
// one transaction in flight; the next is taken while a result waits at the output
// after rst a clearing pass over all POOL_BYTES/ALIGN_BYTES header entries runs before the
// first transaction; configuration writes are taken during it
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator #(
  parameter int POOL_BYTES   = 65536,
  parameter int ALIGN_BYTES  = 16,
  parameter int HEADER_BYTES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [ffha_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic [15:0]                request_bytes,
  input  logic [15:0]                payload_offset,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 status,
  output logic [15:0]                granted_offset,
  output logic [16:0]                live_bytes,
  output logic [16:0]                peak_bytes,
  output logic [16:0]                largest_free,
  output logic [16:0]                largest_request,
  output logic                       high_water_step
);

  ffha_pkg::dp_cmd_t  cmd;
  ffha_pkg::dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ffha_dp #(
    .POOL_BYTES   (POOL_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .command         (command),
    .request_bytes   (request_bytes),
    .payload_offset  (payload_offset),
    .status          (status),
    .granted_offset  (granted_offset),
    .live_bytes      (live_bytes),
    .peak_bytes      (peak_bytes),
    .largest_free    (largest_free),
    .largest_request (largest_request),
    .high_water_step (high_water_step)
  );

  `FFHA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `FFHA_ASSERT_NOW(a_status_range, clk, rst, out_valid, status <= ffha_pkg::ST_CORRUPT)
  `FFHA_ASSERT_NOW(a_grant_only_ok, clk, rst, out_valid && status != ffha_pkg::ST_OK, granted_offset == 16'd0)
  `FFHA_ASSERT_NOW(a_peak_covers_live, clk, rst, out_valid, peak_bytes >= live_bytes)

endmodule

>>> sim/first_fit_heap_allocator_tb.sv
// self-checking testbench for the first fit heap allocator
// depends on ffha_pkg and first_fit_heap_allocator; predicts each result in place
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int GRANULES = 4096;
  localparam int HDR = 16;
  localparam int ALN = 16;
  localparam int POOL = 65536;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] granted;
    logic [16:0] live;
    logic [16:0] peak;
    logic [16:0] lfree;
    logic [16:0] maxreq;
    logic        step;
  } result_t;

  typedef struct {
    logic        cmd;
    logic [15:0] req;
    logic [15:0] off;
    logic        known;
    logic [2:0]  want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = 1'b0;
  logic [15:0] request_bytes = '0;
  logic [15:0] payload_offset = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [15:0] granted_offset;
  logic [16:0] live_bytes, peak_bytes, largest_free, largest_request;
  logic high_water_step;

  first_fit_heap_allocator u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .request_bytes(request_bytes), .payload_offset(payload_offset),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .granted_offset(granted_offset), .live_bytes(live_bytes),
    .peak_bytes(peak_bytes), .largest_free(largest_free),
    .largest_request(largest_request), .high_water_step(high_water_step)
  );

  always #6 clk = ~clk;

  // heap mirror
  int unsigned blk_size [GRANULES];
  int unsigned blk_next [GRANULES];
  bit          blk_has_next [GRANULES];
  logic [1:0]  blk_tag [GRANULES];
  int unsigned list_head;
  bit          list_valid;
  int unsigned live_cnt, peak_cnt, max_req, level, floor_val;

  result_t pending_results[$];
  int unsigned held_offsets[$];
  int unsigned released_offsets[$];
  int errors = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;

  function automatic int unsigned largest_free_payload();
    int unsigned best, g, n;
    bit v;
    best = 0; g = list_head; v = list_valid; n = 0;
    while (v && n < GRANULES) begin
      if (blk_size[g] > best) best = blk_size[g];
      v = blk_has_next[g];
      g = blk_next[g];
      n++;
    end
    return best;
  endfunction

  function automatic void heap_alloc(input int unsigned req, inout result_t r);
    int unsigned size, cur, prev, n, ng;
    bit v, pv;
    size = (req + ALN - 1) & ~(ALN - 1);
    cur = list_head; v = list_valid; prev = 0; pv = 0; n = 0;
    while (v && n < GRANULES) begin
      if (blk_size[cur] >= size) begin
        if (blk_size[cur] > size + HDR + ALN) begin
          ng = cur + (HDR + size) / ALN;
          if (ng < GRANULES) begin
            blk_size[ng] = blk_size[cur] - size - HDR;
            blk_next[ng] = blk_next[cur];
            blk_has_next[ng] = blk_has_next[cur];
            blk_tag[ng] = TAG_FREE;
            blk_size[cur] = size;
            blk_next[cur] = ng;
            blk_has_next[cur] = 1;
          end
        end
        if (pv) begin
          blk_next[prev] = blk_next[cur];
          blk_has_next[prev] = blk_has_next[cur];
        end else begin
          list_head = blk_next[cur];
          list_valid = blk_has_next[cur];
        end
        blk_tag[cur] = TAG_USED;
        r.granted = cur * ALN + HDR;
        live_cnt += blk_size[cur] + HDR;
        if (size > max_req) max_req = size;
        if (live_cnt > peak_cnt) begin
          int unsigned lvl;
          peak_cnt = live_cnt;
          lvl = (level != 0) ? level * 2 : floor_val;
          if (peak_cnt >= lvl) begin
            level = lvl;
            r.step = 1'b1;
          end
        end
        r.status = ST_OK;
        return;
      end
      prev = cur; pv = 1;
      v = blk_has_next[cur];
      cur = blk_next[cur];
      n++;
    end
    r.status = ST_NOMEM;
    r.lfree = largest_free_payload();
  endfunction

  function automatic logic [2:0] heap_free(input int unsigned p);
    int unsigned b, g, blk, cur, prev, n, nx;
    bit v, pv;
    if (p < HDR) return ST_BADPTR;
    b = p - HDR;
    if (b >= POOL) return ST_BADPTR;
    if (b % ALN) return ST_CORRUPT;
    g = b / ALN;
    if (blk_tag[g] == TAG_FREE) return ST_DBLFREE;
    if (blk_tag[g] != TAG_USED) return ST_CORRUPT;
    blk_tag[g] = TAG_FREE;
    if (live_cnt >= blk_size[g] + HDR) live_cnt -= blk_size[g] + HDR;
    cur = list_head; v = list_valid; prev = 0; pv = 0; n = 0;
    while (v && cur < g && n < GRANULES) begin
      prev = cur; pv = 1;
      v = blk_has_next[cur];
      cur = blk_next[cur];
      n++;
    end
    blk = g;
    if (pv && prev * ALN + HDR + blk_size[prev] == b) begin
      blk_size[prev] += HDR + blk_size[g];
      blk_tag[g] = TAG_NONE;
      blk = prev;
    end else begin
      blk_next[g] = cur;
      blk_has_next[g] = v;
      if (pv) begin
        blk_next[prev] = g;
        blk_has_next[prev] = 1;
      end else begin
        list_head = g;
        list_valid = 1;
      end
    end
    if (blk_has_next[blk]) begin
      nx = blk_next[blk];
      if (blk * ALN + HDR + blk_size[blk] == nx * ALN) begin
        blk_size[blk] += HDR + blk_size[nx];
        blk_next[blk] = blk_next[nx];
        blk_has_next[blk] = blk_has_next[nx];
        blk_tag[nx] = TAG_NONE;
      end
    end
    return ST_OK;
  endfunction

  function automatic result_t heap_step(input logic cmd, input int unsigned req,
                                        input int unsigned off);
    result_t r;
    r = '{default: '0};
    if (cmd == CMD_ALLOC) begin
      if (req == 0) r.status = ST_ZERO;
      else heap_alloc(req, r);
    end else begin
      r.status = heap_free(off);
    end
    r.live = live_cnt[16:0];
    r.peak = peak_cnt[16:0];
    r.maxreq = max_req[16:0];
    return r;
  endfunction

  task automatic send_transaction(input logic cmd, input logic [15:0] req,
                                  input logic [15:0] off, input logic known,
                                  input logic [2:0] want);
    result_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd;
    request_bytes = req;
    payload_offset = off;
    do @(posedge clk); while (in_stall);
    r = heap_step(cmd, req, off);
    if (known && r.status !== want) begin
      $error("status expected %0d actual %0d (typed)", want, r.status);
      errors++;
    end
    pending_results.push_back(r);
    if (cmd == CMD_ALLOC && r.status == ST_OK) held_offsets.push_back(r.granted);
    if (cmd != CMD_ALLOC && r.status == ST_OK) released_offsets.push_back(off);
    @(negedge clk);
  endtask

  task automatic settle_and_configure(input logic [CFG_W-1:0] value);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    floor_val = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  always @(negedge clk) out_stall = ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction pending");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status); errors++;
        end
        if (granted_offset !== e.granted) begin
          $error("granted_offset expected %0d actual %0d", e.granted, granted_offset);
          errors++;
        end
        if (live_bytes !== e.live) begin
          $error("live_bytes expected %0d actual %0d", e.live, live_bytes); errors++;
        end
        if (peak_bytes !== e.peak) begin
          $error("peak_bytes expected %0d actual %0d", e.peak, peak_bytes); errors++;
        end
        if (largest_free !== e.lfree) begin
          $error("largest_free expected %0d actual %0d", e.lfree, largest_free);
          errors++;
        end
        if (largest_request !== e.maxreq) begin
          $error("largest_request expected %0d actual %0d", e.maxreq, largest_request);
          errors++;
        end
        if (high_water_step !== e.step) begin
          $error("high_water_step expected %0d actual %0d", e.step, high_water_step);
          errors++;
        end
      end
    end
  end

  initial begin
    #120_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    row_t rows[$];
    int unsigned floors[5];
    int unsigned idle_mix[5];
    int unsigned stall_mix[5];
    int unsigned sel, idx, req;
    foreach (blk_size[i]) begin
      blk_size[i] = 0; blk_next[i] = 0; blk_has_next[i] = 0; blk_tag[i] = TAG_NONE;
    end
    blk_size[0] = POOL - HDR;
    blk_tag[0] = TAG_FREE;
    list_head = 0; list_valid = 1;
    live_cnt = 0; peak_cnt = 0; max_req = 0; level = 0; floor_val = FLOOR_RESET;

    rows = '{
      '{CMD_ALLOC, 16'd0,     16'd0,     1'b1, ST_ZERO},
      '{~CMD_ALLOC, 16'd0,    16'd0,     1'b1, ST_BADPTR},
      '{~CMD_ALLOC, 16'd0,    16'd15,    1'b1, ST_BADPTR},
      '{~CMD_ALLOC, 16'd0,    16'hFFFF,  1'b1, ST_CORRUPT},
      '{~CMD_ALLOC, 16'd0,    16'd17,    1'b1, ST_CORRUPT},
      '{~CMD_ALLOC, 16'd0,    16'd16,    1'b1, ST_DBLFREE},
      '{CMD_ALLOC, 16'd1,     16'd0,     1'b1, ST_OK},
      '{~CMD_ALLOC, 16'd0,    16'd16,    1'b1, ST_OK},
      '{~CMD_ALLOC, 16'd0,    16'd16,    1'b1, ST_DBLFREE},
      '{CMD_ALLOC, 16'hFFFF,  16'hFFFF,  1'b1, ST_NOMEM},
      '{CMD_ALLOC, 16'd65520, 16'd0,     1'b1, ST_OK},
      '{CMD_ALLOC, 16'd16,    16'd0,     1'b1, ST_NOMEM},
      '{~CMD_ALLOC, 16'd0,    16'd16,    1'b1, ST_OK},
      '{CMD_ALLOC, 16'd100,   16'd0,     1'b0, ST_OK},
      '{CMD_ALLOC, 16'd33,    16'd0,     1'b0, ST_OK},
      '{CMD_ALLOC, 16'd48,    16'd0,     1'b0, ST_OK},
      '{~CMD_ALLOC, 16'd0,    16'd144,   1'b0, ST_OK},
      '{~CMD_ALLOC, 16'd0,    16'd16,    1'b0, ST_OK},
      '{~CMD_ALLOC, 16'd0,    16'd208,   1'b0, ST_OK},
      '{~CMD_ALLOC, 16'd0,    16'd144,   1'b0, ST_OK},
      '{~CMD_ALLOC, 16'd0,    16'd208,   1'b1, ST_CORRUPT}
    };
    floors = '{32'd1, 32'd65536, 32'd0, 32'd4096, 32'd16384};
    idle_mix = '{32'd0, 32'd62, 32'd0, 32'd17, 32'd0};
    stall_mix = '{32'd0, 32'd0, 32'd62, 32'd17, 32'd30};

    @(negedge clk);
    repeat (7) @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send_transaction(rows[i].cmd, rows[i].req, rows[i].off,
                                       rows[i].known, rows[i].want);
    held_offsets.delete();
    released_offsets.delete();

    for (int ph = 0; ph < 5; ph++) begin
      settle_and_configure(ph == 4 ? $urandom_range(2, 65535) : floors[ph]);
      sender_idle_pct = idle_mix[ph];
      stall_pct = stall_mix[ph];
      for (int k = 0; k < 80; k++) begin
        sel = $urandom_range(99);
        if (sel < 50) begin
          req = ($urandom_range(9) == 0) ? $urandom_range(1, 65535)
                                         : $urandom_range(1, 600);
          send_transaction(CMD_ALLOC, req, $urandom, 1'b0, ST_OK);
        end else if (sel < 84 && held_offsets.size() > 0) begin
          idx = $urandom_range(held_offsets.size() - 1);
          req = held_offsets[idx];
          held_offsets.delete(idx);
          send_transaction(~CMD_ALLOC, $urandom, req, 1'b0, ST_OK);
        end else if (sel < 88 && released_offsets.size() > 0) begin
          idx = $urandom_range(released_offsets.size() - 1);
          send_transaction(~CMD_ALLOC, $urandom, released_offsets[idx], 1'b0, ST_OK);
        end else if (sel < 91) begin
          send_transaction(CMD_ALLOC, 16'd0, $urandom, 1'b0, ST_OK);
        end else if (sel < 94) begin
          send_transaction(~CMD_ALLOC, $urandom, $urandom_range(15), 1'b0, ST_OK);
        end else begin
          send_transaction(~CMD_ALLOC, $urandom, $urandom, 1'b0, ST_OK);
        end
      end
    end

    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
